[rtl/cau_pkg.sv]
// shared types and codes for the complex arithmetic unit
`default_nettype none

package cau_pkg;

   // operation codes carried by the request word
   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   // status codes returned with each response word
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   // classification attached by the front part
   typedef struct packed {
      cmd_type op;
      logic    div_zero;
   } class_type;

   localparam int CLASS_BITS = $bits(class_type);

endpackage

`default_nettype wire

[rtl/cau_fifo.sv]
// small register queue with push/full and pop/empty sides
`default_nettype none

module cau_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count missed a pop");

endmodule

`default_nettype wire

[rtl/cau_front.sv]
// front part: takes request words, classifies them and packs them for the queue
`default_nettype none

module cau_front #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                         req_push,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic signed [DATA_WIDTH-1:0] req_a_re,
   input  wire logic signed [DATA_WIDTH-1:0] req_a_im,
   input  wire logic signed [DATA_WIDTH-1:0] req_b_re,
   input  wire logic signed [DATA_WIDTH-1:0] req_b_im,
   output logic                              item_push,
   output logic [cau_pkg::CLASS_BITS+4*DATA_WIDTH-1:0] item_data
);
   import cau_pkg::*;

   class_type cls;

   // classify operation and flag a zero divisor early
   always_comb begin
      cls.op       = cmd_type'(req_cmd);
      cls.div_zero = (cmd_type'(req_cmd) == CMD_DIV) &&
                     (req_b_re == '0) && (req_b_im == '0);
   end

   assign item_push = req_push;
   assign item_data = {cls, req_a_re, req_a_im, req_b_re, req_b_im};

endmodule

`default_nettype wire

[rtl/cau_back.sv]
// back part: product stage, sum stage, pipelined divider and result fit
`default_nettype none

module cau_back #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic item_empty,
   input  wire logic [cau_pkg::CLASS_BITS+4*DATA_WIDTH-1:0] item_data,
   output logic      item_pop,
   input  wire logic res_full,
   output logic      res_push,
   output logic [2*DATA_WIDTH+1:0] res_data
);
   import cau_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int MW = 2 * DW;
   localparam int QB = DW + FRAC_BITS + 1;
   localparam int XW = MW + FRAC_BITS + 2;
   localparam int NV = QB + 3;
   localparam logic [MW:0] HALF = (MW + 1)'((1 << FRAC_BITS) >> 1);

   typedef struct packed {
      cmd_type               op;
      logic                  zero;
      logic signed [MW-1:0]  p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
      logic signed [DW:0]    s_re, s_im;
   } prod_type;

   typedef struct packed {
      cmd_type     op;
      logic        zero;
      logic        neg_r, neg_i;
      logic [MW-1:0] mag_r, mag_i, den;
   } sum_type;

   typedef struct packed {
      cmd_type       op;
      logic          zero;
      logic          neg_r, neg_i, sat_r, sat_i;
      logic [MW-1:0] mag_r, mag_i, den, rem_r, rem_i;
      logic [QB-1:0] x_r, x_i, q_r, q_i;
   } div_type;

   class_type            cls;
   logic signed [DW-1:0] ar, ai, br, bi;
   logic                 advance;
   logic [NV-1:0]        vld_ff, vld_in;
   prod_type             pr_ff, pr_in;
   sum_type              sm_ff, sm_in;
   div_type              dv_ff [QB+1];
   div_type              dv_in [QB+1];

   assign {cls, ar, ai, br, bi} = item_data;

   // whole pipeline moves unless the last word is blocked
   assign advance  = !vld_ff[NV-1] || !res_full;
   assign item_pop = advance && !item_empty;
   assign res_push = vld_ff[NV-1] && !res_full;

   // product stage: one multiply per product, then a register
   always_comb begin
      pr_in.op   = cls.op;
      pr_in.zero = cls.div_zero;
      pr_in.p_rr = ar * br;
      pr_in.p_ii = ai * bi;
      pr_in.p_ri = ar * bi;
      pr_in.p_ir = ai * br;
      pr_in.sq_r = br * br;
      pr_in.sq_i = bi * bi;
      if (cls.op == CMD_SUB) begin
         pr_in.s_re = (DW + 1)'(ar) - (DW + 1)'(br);
         pr_in.s_im = (DW + 1)'(ai) - (DW + 1)'(bi);
      end else begin
         pr_in.s_re = (DW + 1)'(ar) + (DW + 1)'(br);
         pr_in.s_im = (DW + 1)'(ai) + (DW + 1)'(bi);
      end
   end

   // sum stage: signed sums, sign and magnitude, product rounding
   always_comb begin
      logic signed [MW:0] sum_r, sum_i;
      logic [MW:0]        abs_r, abs_i;
      sum_r = '0;
      sum_i = '0;
      unique case (pr_ff.op)
         CMD_MUL: begin
            sum_r = (MW + 1)'(pr_ff.p_rr) - (MW + 1)'(pr_ff.p_ii);
            sum_i = (MW + 1)'(pr_ff.p_ri) + (MW + 1)'(pr_ff.p_ir);
         end
         CMD_DIV: begin
            sum_r = (MW + 1)'(pr_ff.p_rr) + (MW + 1)'(pr_ff.p_ii);
            sum_i = (MW + 1)'(pr_ff.p_ir) - (MW + 1)'(pr_ff.p_ri);
         end
         CMD_ADD, CMD_SUB: begin
            sum_r = (MW + 1)'(pr_ff.s_re);
            sum_i = (MW + 1)'(pr_ff.s_im);
         end
         default: begin
            sum_r = '0;
            sum_i = '0;
         end
      endcase
      abs_r = sum_r[MW] ? -sum_r : sum_r;
      abs_i = sum_i[MW] ? -sum_i : sum_i;
      sm_in.op    = pr_ff.op;
      sm_in.zero  = pr_ff.zero;
      sm_in.neg_r = sum_r[MW];
      sm_in.neg_i = sum_i[MW];
      sm_in.den   = MW'(pr_ff.sq_r) + MW'(pr_ff.sq_i);
      if (pr_ff.op == CMD_MUL) begin
         sm_in.mag_r = MW'((abs_r + HALF) >> FRAC_BITS);
         sm_in.mag_i = MW'((abs_i + HALF) >> FRAC_BITS);
      end else begin
         sm_in.mag_r = abs_r[MW-1:0];
         sm_in.mag_i = abs_i[MW-1:0];
      end
   end

   // divider setup and one quotient bit per stage
   always_comb begin
      dv_in[0].op    = sm_ff.op;
      dv_in[0].zero  = sm_ff.zero;
      dv_in[0].neg_r = sm_ff.neg_r;
      dv_in[0].neg_i = sm_ff.neg_i;
      dv_in[0].mag_r = sm_ff.mag_r;
      dv_in[0].mag_i = sm_ff.mag_i;
      dv_in[0].den   = sm_ff.den;
      dv_in[0].sat_r = (sm_ff.mag_r >> DW) >= sm_ff.den;
      dv_in[0].sat_i = (sm_ff.mag_i >> DW) >= sm_ff.den;
      dv_in[0].rem_r = sm_ff.mag_r >> DW;
      dv_in[0].rem_i = sm_ff.mag_i >> DW;
      dv_in[0].x_r   = {sm_ff.mag_r[DW-1:0], (FRAC_BITS + 1)'(0)};
      dv_in[0].x_i   = {sm_ff.mag_i[DW-1:0], (FRAC_BITS + 1)'(0)};
      dv_in[0].q_r   = '0;
      dv_in[0].q_i   = '0;
      for (int k = 0; k < QB; k++) begin
         logic [MW:0] t_r, t_i;
         logic        b_r, b_i;
         t_r = {dv_ff[k].rem_r, dv_ff[k].x_r[QB-1]};
         t_i = {dv_ff[k].rem_i, dv_ff[k].x_i[QB-1]};
         b_r = t_r >= {1'b0, dv_ff[k].den};
         b_i = t_i >= {1'b0, dv_ff[k].den};
         dv_in[k+1]       = dv_ff[k];
         dv_in[k+1].rem_r = b_r ? MW'(t_r - {1'b0, dv_ff[k].den}) : t_r[MW-1:0];
         dv_in[k+1].rem_i = b_i ? MW'(t_i - {1'b0, dv_ff[k].den}) : t_i[MW-1:0];
         dv_in[k+1].x_r   = dv_ff[k].x_r << 1;
         dv_in[k+1].x_i   = dv_ff[k].x_i << 1;
         dv_in[k+1].q_r   = {dv_ff[k].q_r[QB-2:0], b_r};
         dv_in[k+1].q_i   = {dv_ff[k].q_i[QB-2:0], b_i};
      end
   end

   // valid chain
   always_comb begin
      vld_in = vld_ff;
      if (advance) begin
         vld_in = {vld_ff[NV-2:0], !item_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pr_ff <= pr_in;
         sm_ff <= sm_in;
         for (int k = 0; k <= QB; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // final rounding, clamp and status
   always_comb begin
      div_type       d;
      logic [XW-1:0] m_r, m_i, l_r, l_i, c_r, c_i;
      logic          o_r, o_i;
      logic [DW-1:0] v_r, v_i;
      status_type    st;
      d = dv_ff[QB];
      if (d.op == CMD_DIV) begin
         m_r = (XW'(d.q_r) + 1'b1) >> 1;
         m_i = (XW'(d.q_i) + 1'b1) >> 1;
      end else begin
         m_r = XW'(d.mag_r);
         m_i = XW'(d.mag_i);
      end
      l_r = d.neg_r ? (XW'(1) << (DW - 1)) : (XW'(1) << (DW - 1)) - 1'b1;
      l_i = d.neg_i ? (XW'(1) << (DW - 1)) : (XW'(1) << (DW - 1)) - 1'b1;
      o_r = (m_r > l_r) || ((d.op == CMD_DIV) && d.sat_r);
      o_i = (m_i > l_i) || ((d.op == CMD_DIV) && d.sat_i);
      c_r = o_r ? l_r : m_r;
      c_i = o_i ? l_i : m_i;
      v_r = d.neg_r ? DW'(-c_r) : c_r[DW-1:0];
      v_i = d.neg_i ? DW'(-c_i) : c_i[DW-1:0];
      st  = (o_r || o_i) ? ST_OVF : ST_OK;
      if ((d.op == CMD_DIV) && d.zero) begin
         v_r = '0;
         v_i = '0;
         st  = ST_DIVZ;
      end
      res_data = {v_r, v_i, st};
   end

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NV-1] && res_full) |=> (vld_ff == $past(vld_ff)))
      else $error("pipeline moved while output was blocked");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> advance)
      else $error("queue popped while pipeline stalled");

   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> vld_ff[0])
      else $error("popped word did not enter the pipeline");

endmodule

`default_nettype wire

[rtl/complex_arithmetic_unit_core.sv]
// top level of the complex arithmetic unit
`default_nettype none

// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fraction bits). One request word is taken per
// cycle while req_full is low, and one response word with status is returned
// per request, in order. An accepted request passes through the front queue,
// the product stage, the sum stage, the divider setup stage and a divider
// pipeline of DATA_WIDTH + FRAC_BITS + 1 stages with one quotient bit per
// stage, and then enters the response queue. Add, subtract and multiply
// pass through the same pipeline so responses keep request order. A
// four-word queue sits between the front and the back part and a two-word
// queue holds responses. req_full rises only when the response queue is full
// and the pipeline has stalled long enough for the front queue to fill.
module complex_arithmetic_unit_core #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_push,
   output logic                              req_full,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic signed [DATA_WIDTH-1:0] req_a_re,
   input  wire logic signed [DATA_WIDTH-1:0] req_a_im,
   input  wire logic signed [DATA_WIDTH-1:0] req_b_re,
   input  wire logic signed [DATA_WIDTH-1:0] req_b_im,
   output logic                              rsp_empty,
   input  wire logic                         rsp_pop,
   output logic signed [DATA_WIDTH-1:0]      rsp_res_re,
   output logic signed [DATA_WIDTH-1:0]      rsp_res_im,
   output logic [1:0]                        rsp_status
);
   import cau_pkg::*;

   localparam int IW = CLASS_BITS + 4 * DATA_WIDTH;
   localparam int RW = 2 * DATA_WIDTH + 2;

   logic          item_push, item_pop, item_empty;
   logic [IW-1:0] item_in, item_out;
   logic          res_push, res_full;
   logic [RW-1:0] res_in, res_out;

   // front part
   cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .req_push (req_push),
      .req_cmd  (req_cmd),
      .req_a_re (req_a_re),
      .req_a_im (req_a_im),
      .req_b_re (req_b_re),
      .req_b_im (req_b_im),
      .item_push(item_push),
      .item_data(item_in)
   );

   // queue between front and back
   cau_fifo #(.WIDTH(IW), .DEPTH(4)) u_item_q (
      .clock    (clock),
      .reset    (reset),
      .push     (item_push),
      .push_data(item_in),
      .full     (req_full),
      .pop      (item_pop),
      .pop_data (item_out),
      .empty    (item_empty)
   );

   // back part
   cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_empty(item_empty),
      .item_data (item_out),
      .item_pop  (item_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_in)
   );

   // response queue
   cau_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_in),
      .full     (res_full),
      .pop      (rsp_pop),
      .pop_data (res_out),
      .empty    (rsp_empty)
   );

   assign {rsp_res_re, rsp_res_im, rsp_status} = res_out;

endmodule

`default_nettype wire
